/* sv/mds_pkg.sv */
package mds_pkg;

    // default geometry
    localparam int GRID_ROWS_DEF   = 16;
    localparam int GRID_COLS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 32;

    // configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 4;
    localparam logic [CFG_AW-1:0] REG_ENTRY_ROW = 1'd0;
    localparam logic [CFG_AW-1:0] REG_ENTRY_COL = 1'd1;
    localparam logic [CFG_DW-1:0] ENTRY_ROW_RST = 4'd1;
    localparam logic [CFG_DW-1:0] ENTRY_COL_RST = 4'd0;

    // cell kinds
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALT_WALL = 2'd3;

    // result count
    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

    // neighbour order
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_DOWN  = 2'd1;
    localparam dir_t DIR_LEFT  = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

endpackage

/* sv/maze_dfs_stack_search.sv */
// Load: one cell request per cycle while idle, written straight into the grid memory.
// Search (request with last_cell): a clearing pass over the visited marks, then per
// expanded cell a fetch, a read for each in-grid neighbour (an edge side is skipped
// without a read) and a pop (an empty stack ends the search); an entry outside the grid goes straight to done.
// Memory reads are registered, which sets this pace; done strobes for one cycle
// and cannot be stalled. rst_n clears control state only; memories hold garbage until written.
module maze_dfs_stack_search #(
    parameter int GRID_ROWS   = mds_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS   = mds_pkg::GRID_COLS_DEF,
    parameter int STACK_DEPTH = mds_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mds_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [mds_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [mds_pkg::KIND_W-1:0]  cell_kind,
    input  logic                        last_cell,
    output logic                        done,
    output logic                        found,
    output logic [mds_pkg::CNT_W-1:0]   visited_count,
    output logic                        stack_overflow
);
    import mds_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int EW    = RW + CW;
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam int STW   = $clog2(STACK_DEPTH + 1);

    localparam logic [AW-1:0]  LAST_ADDR = AW'(CELLS - 1);
    localparam logic [RW-1:0]  LAST_ROW  = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0]  LAST_COL  = CW'(GRID_COLS - 1);
    localparam logic [STW-1:0] FULL      = STW'(STACK_DEPTH);

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CLEAR     = 4'd1;
    localparam logic [3:0] ST_CLEAR_END = 4'd2;
    localparam logic [3:0] ST_FETCH     = 4'd3;
    localparam logic [3:0] ST_CHECK     = 4'd4;
    localparam logic [3:0] ST_NB_ISSUE  = 4'd5;
    localparam logic [3:0] ST_NB_EVAL   = 4'd6;
    localparam logic [3:0] ST_POP       = 4'd7;
    localparam logic [3:0] ST_POP_WAIT  = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        cell_addr = AW'(int'(row) * GRID_COLS + int'(col));
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [CFG_DW-1:0]   entry_row_reg, entry_col_reg;
    logic [AW-1:0]       load_pos_reg, load_pos_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [AW-1:0]       clr_prev_reg, clr_prev_next;
    logic                clr_pend_reg, clr_pend_next;
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [RW-1:0]       nb_row_reg, nb_row_next;
    logic [CW-1:0]       nb_col_reg, nb_col_next;
    dir_t                dir_reg, dir_next;
    logic [STW-1:0]      top_reg, top_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                found_reg, found_next;

    // grid memory: {visited, kind}
    logic [KIND_W:0]     grid_mem [CELLS];
    logic [KIND_W:0]     grid_rd_reg;
    logic                grid_we;
    logic [AW-1:0]       grid_waddr, grid_raddr;
    logic [KIND_W:0]     grid_wdata;

    // stack memory: {row, col}
    logic [EW-1:0]       stack_mem [STACK_DEPTH];
    logic [EW-1:0]       stack_rd_reg;
    logic                stack_we;
    logic [SIW-1:0]      stack_raddr;

    logic [KIND_W-1:0]   rd_kind;
    logic                rd_visited;
    logic                nb_ok;
    logic [RW-1:0]       side_row;
    logic [CW-1:0]       side_col;
    logic [STW-1:0]      top_dec;

    assign rd_kind    = grid_rd_reg[KIND_W-1:0];
    assign rd_visited = grid_rd_reg[KIND_W];
    assign top_dec    = top_reg - STW'(1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_row_reg <= ENTRY_ROW_RST;
            entry_col_reg <= ENTRY_COL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ENTRY_ROW: entry_row_reg <= cfg_wdata;
                REG_ENTRY_COL: entry_col_reg <= cfg_wdata;
            endcase
        end
    end

    // neighbour selection for the current direction
    always_comb
    begin
        side_row = cur_row_reg;
        side_col = cur_col_reg;
        nb_ok    = 1'b0;
        unique case (dir_reg)
            DIR_UP:
            begin
                nb_ok    = (cur_row_reg != '0);
                side_row = cur_row_reg - RW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok    = (cur_row_reg != LAST_ROW);
                side_row = cur_row_reg + RW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok    = (cur_col_reg != '0);
                side_col = cur_col_reg - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok    = (cur_col_reg != LAST_COL);
                side_col = cur_col_reg + CW'(1);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        clr_addr_next = clr_addr_reg;
        clr_prev_next = clr_prev_reg;
        clr_pend_next = clr_pend_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        nb_row_next   = nb_row_reg;
        nb_col_next   = nb_col_reg;
        dir_next      = dir_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        found_next    = found_reg;
        grid_we       = 1'b0;
        grid_waddr    = load_pos_reg;
        grid_wdata    = {1'b0, cell_kind};
        grid_raddr    = cell_addr(cur_row_reg, cur_col_reg);
        stack_we      = 1'b0;
        stack_raddr   = top_dec[SIW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    grid_we = 1'b1;
                    load_pos_next = (load_pos_reg == LAST_ADDR) ? '0
                                                                : load_pos_reg + AW'(1);
                    if (last_cell)
                    begin
                        load_pos_next = '0;
                        top_next      = '0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        found_next    = 1'b0;
                        clr_addr_next = '0;
                        clr_pend_next = 1'b0;
                        cur_row_next  = RW'(entry_row_reg);
                        cur_col_next  = CW'(entry_col_reg);
                        if (int'(entry_row_reg) < GRID_ROWS && int'(entry_col_reg) < GRID_COLS)
                            state_next = ST_CLEAR;
                        else
                            state_next = ST_DONE;
                    end
                end
            end
            // read one entry, write the previous one back with its mark cleared
            ST_CLEAR:
            begin
                grid_raddr    = clr_addr_reg;
                grid_we       = clr_pend_reg;
                grid_waddr    = clr_prev_reg;
                grid_wdata    = {1'b0, rd_kind};
                clr_pend_next = 1'b1;
                clr_prev_next = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_CLEAR_END;
                else
                    clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_CLEAR_END:
            begin
                grid_we       = 1'b1;
                grid_waddr    = clr_prev_reg;
                grid_wdata    = {1'b0, rd_kind};
                clr_pend_next = 1'b0;
                state_next    = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_CHECK;
            end
            // current cell: exit test, then mark
            ST_CHECK:
            begin
                if (rd_kind == KIND_EXIT)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (!rd_visited)
                    begin
                        grid_we    = 1'b1;
                        grid_waddr = cell_addr(cur_row_reg, cur_col_reg);
                        grid_wdata = {1'b1, rd_kind};
                        if (count_reg != COUNT_MAX)
                            count_next = count_reg + CNT_W'(1);
                    end
                    dir_next   = DIR_UP;
                    state_next = ST_NB_ISSUE;
                end
            end
            ST_NB_ISSUE:
            begin
                if (nb_ok)
                begin
                    grid_raddr  = cell_addr(side_row, side_col);
                    nb_row_next = side_row;
                    nb_col_next = side_col;
                    state_next  = ST_NB_EVAL;
                end
                else if (dir_reg == DIR_RIGHT)
                    state_next = ST_POP;
                else
                    dir_next = dir_reg + 2'd1;
            end
            // push the neighbour if it is not a wall and unvisited (a full stack sets overflow instead)
            ST_NB_EVAL:
            begin
                if (rd_kind != KIND_WALL && rd_kind != KIND_ALT_WALL && !rd_visited)
                begin
                    if (top_reg == FULL)
                        ovf_next = 1'b1;
                    else
                    begin
                        stack_we = 1'b1;
                        top_next = top_reg + STW'(1);
                    end
                end
                if (dir_reg == DIR_RIGHT)
                    state_next = ST_POP;
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_NB_ISSUE;
                end
            end
            ST_POP:
            begin
                if (top_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    top_next   = top_dec;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                cur_row_next = stack_rd_reg[EW-1:CW];
                cur_col_next = stack_rd_reg[CW-1:0];
                state_next   = ST_FETCH;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_pos_reg <= '0;
            clr_addr_reg <= '0;
            clr_pend_reg <= 1'b0;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            dir_reg      <= DIR_UP;
            top_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            clr_addr_reg <= clr_addr_next;
            clr_pend_reg <= clr_pend_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            dir_reg      <= dir_next;
            top_reg      <= top_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            found_reg    <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        clr_prev_reg <= clr_prev_next;
        nb_row_reg   <= nb_row_next;
        nb_col_reg   <= nb_col_next;
    end

    // grid memory
    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        grid_rd_reg <= grid_mem[grid_raddr];
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[top_reg[SIW-1:0]] <= {nb_row_reg, nb_col_reg};
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign found          = found_reg;
    assign visited_count  = count_reg;
    assign stack_overflow = ovf_reg;

    // a request without last_cell only loads
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_cell) |=> !busy)
        else $error("load request left the block busy");

    // stack never grows past its depth
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= FULL)
        else $error("stack pointer beyond depth");

    // the result strobe lasts one cycle and frees the block
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // overflow is sticky for the whole search
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg != ST_IDLE) && $past(ovf_reg)) |-> ovf_reg)
        else $error("overflow flag dropped mid search");

    // clearing pass writes back the entry read in the previous cycle
    a_clear_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_pend_reg) |-> (clr_prev_reg + AW'(1) == clr_addr_reg))
        else $error("clearing pass out of step");

endmodule
